[design/ssc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types and widths of the sphere-sphere contact pipeline.
// ----------------------------------------------------------------------------
package ssc_pkg;

   localparam int COORD_W    = 24;               // center and contact coordinates
   localparam int RAD_W      = COORD_W - 1;      // radius
   localparam int MAG_W      = COORD_W + 1;      // |center difference| before the far test
   localparam int SQ_W       = 2 * COORD_W;      // one squared axis
   localparam int DSQ_W      = 2 * COORD_W + 2;  // squared distance, kept even
   localparam int SQRT_STEPS = DSQ_W / 2;
   localparam int ROOT_W     = SQRT_STEPS;
   localparam int REM_W      = ROOT_W + 3;
   localparam int NUM_W      = 2 * COORD_W;      // dividend of the offset divide
   localparam int QUO_W      = COORD_W;          // quotient of the offset divide

   typedef struct packed {
      logic signed [COORD_W-1:0] first_center_x;
      logic signed [COORD_W-1:0] first_center_y;
      logic signed [COORD_W-1:0] first_center_z;
      logic        [RAD_W-1:0]   first_radius;
      logic signed [COORD_W-1:0] second_center_x;
      logic signed [COORD_W-1:0] second_center_y;
      logic signed [COORD_W-1:0] second_center_z;
      logic        [RAD_W-1:0]   second_radius;
   } req_type;

   typedef struct packed {
      logic                      hit;
      logic signed [COORD_W-1:0] contact_x;
      logic signed [COORD_W-1:0] contact_y;
      logic signed [COORD_W-1:0] contact_z;
   } rsp_type;

   // Classified item handed from the front to the back.
   typedef struct packed {
      logic                    hit;
      logic [DSQ_W-1:0]        dsq;
      logic [2:0][COORD_W-1:0] mag;
      logic [2:0]              neg;
      logic [2:0][COORD_W-1:0] c1;
      logic [RAD_W-1:0]        r2;
   } job_type;

   // Sideband carried along the square root pipeline.
   typedef struct packed {
      logic                    hit;
      logic [2:0][COORD_W-1:0] mag;
      logic [2:0]              neg;
      logic [2:0][COORD_W-1:0] c1;
      logic [RAD_W-1:0]        r2;
   } sq_tag_type;

   // Sideband carried along the divider pipeline.
   typedef struct packed {
      logic                    hit;
      logic                    zero;
      logic [2:0]              flip;
      logic [2:0][COORD_W-1:0] c1;
   } dv_tag_type;

endpackage

[design/ssc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_front
// Accepts sphere pairs, forms squared distance and squared radius sum, and
// classifies each pair as hit or miss.
// ----------------------------------------------------------------------------
module ssc_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ssc_pkg::req_type req_data,
   output logic             job_valid,
   input  logic             job_ready,
   output ssc_pkg::job_type job_data
);
   import ssc_pkg::*;

   typedef struct packed {
      logic [2:0][MAG_W-1:0]   mag;
      logic [2:0]              neg;
      logic [2:0][COORD_W-1:0] c1;
      logic [RAD_W-1:0]        r2;
      logic [COORD_W-1:0]      rsum;
   } f1_type;

   typedef struct packed {
      logic                    far;
      logic [2:0][SQ_W-1:0]    sq;
      logic [SQ_W-1:0]         rsq;
      logic [2:0][COORD_W-1:0] mag;
      logic [2:0]              neg;
      logic [2:0][COORD_W-1:0] c1;
      logic [RAD_W-1:0]        r2;
   } f2_type;

   typedef struct packed {
      logic                    far;
      logic [DSQ_W-1:0]        dsq;
      logic [SQ_W-1:0]         rsq;
      logic [2:0][COORD_W-1:0] mag;
      logic [2:0]              neg;
      logic [2:0][COORD_W-1:0] c1;
      logic [RAD_W-1:0]        r2;
   } f3_type;

   logic                    adv;
   logic                    v1_ff, v2_ff, v3_ff;
   f1_type                  f1_in, f1_ff;
   f2_type                  f2_in, f2_ff;
   f3_type                  f3_in, f3_ff;
   logic [2:0][COORD_W-1:0] c1_v, c2_v;
   logic signed [MAG_W-1:0] diff;

   assign adv       = !v3_ff || job_ready;
   assign req_ready = adv;

   assign c1_v = {req_data.first_center_z, req_data.first_center_y, req_data.first_center_x};
   assign c2_v = {req_data.second_center_z, req_data.second_center_y,
                  req_data.second_center_x};

   // stage 1: axis differences and radius sum
   always_comb begin
      diff = '0;
      for (int i = 0; i < 3; i++) begin
         diff = $signed({c2_v[i][COORD_W-1], c2_v[i]}) - $signed({c1_v[i][COORD_W-1], c1_v[i]});
         f1_in.neg[i] = diff[MAG_W-1];
         f1_in.mag[i] = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
      end
      f1_in.c1   = c1_v;
      f1_in.r2   = req_data.second_radius;
      f1_in.rsum = COORD_W'({1'b0, req_data.first_radius}) + COORD_W'({1'b0, req_data.second_radius});
   end

   // stage 2: squares; a difference beyond the radius sum is a sure miss
   always_comb begin
      f2_in.far = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (f1_ff.mag[i] > MAG_W'(f1_ff.rsum)) begin
            f2_in.far = 1'b1;
         end
         f2_in.mag[i] = f1_ff.mag[i][COORD_W-1:0];
         f2_in.sq[i]  = f1_ff.mag[i][COORD_W-1:0] * f1_ff.mag[i][COORD_W-1:0];
      end
      f2_in.rsq = f1_ff.rsum * f1_ff.rsum;
      f2_in.neg = f1_ff.neg;
      f2_in.c1  = f1_ff.c1;
      f2_in.r2  = f1_ff.r2;
   end

   // stage 3: sum of squares
   always_comb begin
      f3_in.far = f2_ff.far;
      f3_in.dsq = DSQ_W'(f2_ff.sq[0]) + DSQ_W'(f2_ff.sq[1]) + DSQ_W'(f2_ff.sq[2]);
      f3_in.rsq = f2_ff.rsq;
      f3_in.mag = f2_ff.mag;
      f3_in.neg = f2_ff.neg;
      f3_in.c1  = f2_ff.c1;
      f3_in.r2  = f2_ff.r2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_ff <= f1_in;
         f2_ff <= f2_in;
         f3_ff <= f3_in;
      end
   end

   assign job_valid    = v3_ff;
   assign job_data.hit = !f3_ff.far && (f3_ff.dsq <= DSQ_W'(f3_ff.rsq));
   assign job_data.dsq = f3_ff.dsq;
   assign job_data.mag = f3_ff.mag;
   assign job_data.neg = f3_ff.neg;
   assign job_data.c1  = f3_ff.c1;
   assign job_data.r2  = f3_ff.r2;

endmodule

[design/ssc_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_queue
// Small FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
module ssc_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  ssc_pkg::job_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output ssc_pkg::job_type out_data
);
   import ssc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign in_ready  = count_ff != CNT_W'(DEPTH);
   assign out_valid = count_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

[design/ssc_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_sqrt
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module ssc_sqrt (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [ssc_pkg::DSQ_W-1:0]  radicand,
   input  ssc_pkg::sq_tag_type in_tag,
   output logic                out_valid,
   output logic [ssc_pkg::ROOT_W-1:0] root,
   output ssc_pkg::sq_tag_type out_tag
);
   import ssc_pkg::*;

   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      logic [DSQ_W-1:0]  rad;
      sq_tag_type        tag;
   } sq_stage_type;

   function automatic sq_stage_type sq_step(sq_stage_type s);
      sq_stage_type     r;
      logic [REM_W-1:0] rem_n;
      logic [REM_W-1:0] trial;
      logic             ge;
      rem_n  = {s.rem[REM_W-3:0], s.rad[DSQ_W-1 -: 2]};
      trial  = REM_W'({s.root, 2'b01});
      ge     = rem_n >= trial;
      r.rem  = ge ? rem_n - trial : rem_n;
      r.root = {s.root[ROOT_W-2:0], ge};
      r.rad  = s.rad << 2;
      r.tag  = s.tag;
      return r;
   endfunction

   sq_stage_type            first;
   sq_stage_type            st_in [SQRT_STEPS];
   sq_stage_type            st_ff [SQRT_STEPS];
   logic [SQRT_STEPS-1:0]   vld_ff;

   assign first.rem  = '0;
   assign first.root = '0;
   assign first.rad  = radicand;
   assign first.tag  = in_tag;

   always_comb begin
      st_in[0] = sq_step(first);
      for (int k = 1; k < SQRT_STEPS; k++) begin
         st_in[k] = sq_step(st_ff[k-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[SQRT_STEPS-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff <= st_in;
      end
   end

   assign out_valid = vld_ff[SQRT_STEPS-1];
   assign root      = st_ff[SQRT_STEPS-1].root;
   assign out_tag   = st_ff[SQRT_STEPS-1].tag;

endmodule

[design/ssc_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_div
// Pipelined three-lane restoring divider over a shared divisor, one quotient
// bit per stage.
// ----------------------------------------------------------------------------
module ssc_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 in_valid,
   input  logic [2:0][ssc_pkg::NUM_W-1:0]       num,
   input  logic [ssc_pkg::COORD_W-1:0]          den,
   input  ssc_pkg::dv_tag_type                  in_tag,
   output logic                                 out_valid,
   output logic [2:0][ssc_pkg::QUO_W-1:0]       quo,
   output ssc_pkg::dv_tag_type                  out_tag
);
   import ssc_pkg::*;

   typedef struct packed {
      logic [2:0][COORD_W-1:0] rem;
      logic [2:0][QUO_W-1:0]   lq;   // dividend bits still to bring down, quotient shifts in
      logic [COORD_W-1:0]      den;
      dv_tag_type              tag;
   } dv_stage_type;

   function automatic dv_stage_type dv_step(dv_stage_type s);
      dv_stage_type       r;
      logic [COORD_W:0]   rn;
      logic               ge;
      r = s;
      for (int i = 0; i < 3; i++) begin
         rn       = {s.rem[i], s.lq[i][QUO_W-1]};
         ge       = rn >= {1'b0, s.den};
         r.rem[i] = ge ? COORD_W'(rn - {1'b0, s.den}) : rn[COORD_W-1:0];
         r.lq[i]  = {s.lq[i][QUO_W-2:0], ge};
      end
      return r;
   endfunction

   dv_stage_type       first;
   dv_stage_type       st_in [QUO_W];
   dv_stage_type       st_ff [QUO_W];
   logic [QUO_W-1:0]   vld_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         first.rem[i] = num[i][NUM_W-1 -: COORD_W];
         first.lq[i]  = num[i][QUO_W-1:0];
      end
      first.den = den;
      first.tag = in_tag;
   end

   always_comb begin
      st_in[0] = dv_step(first);
      for (int k = 1; k < QUO_W; k++) begin
         st_in[k] = dv_step(st_ff[k-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[QUO_W-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff <= st_in;
      end
   end

   assign out_valid = vld_ff[QUO_W-1];
   assign quo       = st_ff[QUO_W-1].lq;
   assign out_tag   = st_ff[QUO_W-1].tag;

endmodule

[design/ssc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_back
// Contact point for classified items: square root, offset scaling, divide,
// saturation and the result register.
// ----------------------------------------------------------------------------
module ssc_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   output logic             job_ready,
   input  ssc_pkg::job_type job_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ssc_pkg::rsp_type rsp_data
);
   import ssc_pkg::*;

   typedef struct packed {
      logic                    hit;
      logic                    zero;
      logic [COORD_W-1:0]      distance;
      logic [COORD_W-1:0]      tmag;
      logic [2:0]              flip;
      logic [2:0][COORD_W-1:0] mag;
      logic [2:0][COORD_W-1:0] c1;
   } t_type;

   typedef struct packed {
      logic                    hit;
      logic                    zero;
      logic [COORD_W-1:0]      distance;
      logic [2:0][NUM_W-1:0]   prod;
      logic [2:0]              flip;
      logic [2:0][COORD_W-1:0] c1;
   } m_type;

   localparam logic signed [COORD_W+1:0] SAT_MAX = (COORD_W+2)'((1 << (COORD_W - 1)) - 1);
   localparam logic signed [COORD_W+1:0] SAT_MIN = -(COORD_W+2)'(1 << (COORD_W - 1));

   logic                    adv;
   sq_tag_type              sq_tag, sq_out_tag;
   logic                    sq_valid;
   logic [ROOT_W-1:0]       root;
   t_type                   t_in, t_ff;
   m_type                   m_in, m_ff;
   logic                    vt_ff, vm_ff;
   logic [2:0][NUM_W-1:0]   num;
   dv_tag_type              dv_tag, dv_out_tag;
   logic                    dv_valid;
   logic [2:0][QUO_W-1:0]   quo;
   logic                    out_vld_ff;
   rsp_type                 rsp_in, rsp_ff;
   logic [COORD_W:0]        tdiff;
   logic [2:0][COORD_W-1:0] contact;
   logic signed [COORD_W+1:0] off, sum;

   assign adv       = !out_vld_ff || rsp_ready;
   assign job_ready = adv;

   assign sq_tag.hit = job_data.hit;
   assign sq_tag.mag = job_data.mag;
   assign sq_tag.neg = job_data.neg;
   assign sq_tag.c1  = job_data.c1;
   assign sq_tag.r2  = job_data.r2;

   ssc_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (job_valid),
      .radicand  (job_data.dsq),
      .in_tag    (sq_tag),
      .out_valid (sq_valid),
      .root      (root),
      .out_tag   (sq_out_tag)
   );

   // travel distance t = distance - r2, kept as sign and magnitude
   always_comb begin
      t_in.distance = root[COORD_W-1:0];
      tdiff     = {1'b0, root[COORD_W-1:0]} - (COORD_W+1)'(sq_out_tag.r2);
      t_in.tmag = tdiff[COORD_W] ? COORD_W'(-tdiff) : tdiff[COORD_W-1:0];
      t_in.hit  = sq_out_tag.hit;
      t_in.zero = root == '0;
      t_in.flip = sq_out_tag.neg ^ {3{tdiff[COORD_W]}};
      t_in.mag  = sq_out_tag.mag;
      t_in.c1   = sq_out_tag.c1;
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         m_in.prod[i] = t_ff.mag[i] * t_ff.tmag;
      end
      m_in.hit      = t_ff.hit;
      m_in.zero     = t_ff.zero;
      m_in.distance = t_ff.distance;
      m_in.flip     = t_ff.flip;
      m_in.c1       = t_ff.c1;
   end

   // half the divisor added in for round-half-away on the magnitude
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num[i] = m_ff.prod[i] + NUM_W'(m_ff.distance >> 1);
      end
   end

   assign dv_tag.hit  = m_ff.hit;
   assign dv_tag.zero = m_ff.zero;
   assign dv_tag.flip = m_ff.flip;
   assign dv_tag.c1   = m_ff.c1;

   ssc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (vm_ff),
      .num       (num),
      .den       (m_ff.distance),
      .in_tag    (dv_tag),
      .out_valid (dv_valid),
      .quo       (quo),
      .out_tag   (dv_out_tag)
   );

   always_comb begin
      off = '0;
      sum = '0;
      for (int i = 0; i < 3; i++) begin
         off = $signed({2'b00, quo[i]});
         sum = $signed({{2{dv_out_tag.c1[i][COORD_W-1]}}, dv_out_tag.c1[i]}) +
               (dv_out_tag.flip[i] ? -off : off);
         if (!dv_out_tag.hit) begin
            contact[i] = '0;
         end else if (dv_out_tag.zero) begin
            contact[i] = dv_out_tag.c1[i];
         end else if (sum > SAT_MAX) begin
            contact[i] = SAT_MAX[COORD_W-1:0];
         end else if (sum < SAT_MIN) begin
            contact[i] = SAT_MIN[COORD_W-1:0];
         end else begin
            contact[i] = sum[COORD_W-1:0];
         end
      end
      rsp_in.hit       = dv_out_tag.hit;
      rsp_in.contact_x = contact[0];
      rsp_in.contact_y = contact[1];
      rsp_in.contact_z = contact[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vt_ff      <= 1'b0;
         vm_ff      <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         vt_ff      <= sq_valid;
         vm_ff      <= vt_ff;
         out_vld_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t_ff   <= t_in;
         m_ff   <= m_in;
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule

[design/sphere_sphere_contact.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_sphere_contact
// Sphere-sphere intersection test with contact point, Q12.12 fixed point.
// ----------------------------------------------------------------------------
// Takes one sphere pair per clock and returns one result per pair, in order.
// A pair is a hit when the squared center distance is no more than the
// squared radius sum (exact). On a hit the contact point is the first center
// moved toward the second by floor(sqrt(dsq)) - second_radius, each axis
// offset rounded half away from zero and the point saturated to 24 bits;
// coincident centers give the first center, a miss gives a zero point.
// Throughput is one transaction per cycle only while req_ready is high; a
// low rsp_ready can fill the queue and pull req_ready low. A transaction
// passes 3 front stages (the first loaded at the accepting edge), the
// queue, 25 square root stages (one result bit each), 2 scaling stages,
// 24 divider stages (one quotient bit each) and the result register.
module sphere_sphere_contact #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ssc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ssc_pkg::rsp_type rsp_data
);
   import ssc_pkg::*;

   // classified transactions, front side and back side of the queue
   logic    fq_valid, fq_ready;
   job_type fq_data;
   logic    qb_valid, qb_ready;
   job_type qb_data;

   // Front: differences, far-apart test, squares, hit decision.
   ssc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .job_valid (fq_valid),
      .job_ready (fq_ready),
      .job_data  (fq_data)
   );

   // Queue lets the front keep accepting, until it fills, while the back is held by rsp_ready.
   ssc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   (fq_data),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_data  (qb_data)
   );

   // Back: distance, offset scale and divide, saturation, output register.
   ssc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (qb_valid),
      .job_ready (qb_ready),
      .job_data  (qb_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
